### hdl/dlq_pkg.sv
// Package for the delta list timer queue.
// Shared widths, defaults, input op codes and cell commands. No dependencies.
package dlq_pkg;

    localparam int DLQ_NUM_TIMERS = 16;
    localparam int DLQ_TIME_BITS  = 32;
    localparam int ID_W           = 4;
    localparam int VALUE_W        = 32;
    localparam int OP_W           = 2;

    typedef enum logic [OP_W-1:0] {
        OP_TIME   = 2'd0,
        OP_SCHED  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    // What a cell loads at the next edge.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHL,      // take right neighbor
        CELL_SHL_ADD,  // take right neighbor, add own delta
        CELL_SHR,      // take left neighbor
        CELL_SHR_SUB,  // take left neighbor, subtract operand
        CELL_LOAD,     // take new id, delta = operand
        CELL_SUB       // own delta minus operand
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd        cmd;
        logic [ID_W-1:0]  new_id;
    } t_cell_ctl;

endpackage

### hdl/dlq_if.sv
// Handshake channels of the delta list timer queue.
// Depends on dlq_pkg for field widths.
interface dlq_in_if;
    logic                        valid;
    logic                        ready;
    logic [dlq_pkg::OP_W-1:0]    op;
    logic [dlq_pkg::ID_W-1:0]    timer_id;
    logic [dlq_pkg::VALUE_W-1:0] value;

    modport source (output valid, output op, output timer_id, output value, input ready);
    modport sink   (input valid, input op, input timer_id, input value, output ready);
endinterface

interface dlq_out_if;
    logic                     valid;
    logic                     ready;
    logic [dlq_pkg::ID_W-1:0] expired_id;

    modport source (output valid, output expired_id, input ready);
    modport sink   (input valid, input expired_id, output ready);
endinterface

### hdl/dlq_cell.sv
// One list position of the timer queue: timer id and delta to predecessor.
// Depends on dlq_pkg; neighbors feed it for shifts in either direction.
module dlq_cell #(
    parameter int TIME_BITS = dlq_pkg::DLQ_TIME_BITS
) (
    input  logic                     i_clk,
    input  dlq_pkg::t_cell_ctl       i_ctl,
    input  logic [TIME_BITS-1:0]     i_operand,
    input  logic [dlq_pkg::ID_W-1:0] i_left_id,
    input  logic [TIME_BITS-1:0]     i_left_delta,
    input  logic [dlq_pkg::ID_W-1:0] i_right_id,
    input  logic [TIME_BITS-1:0]     i_right_delta,
    output logic [dlq_pkg::ID_W-1:0] o_id,
    output logic [TIME_BITS-1:0]     o_delta
);
    import dlq_pkg::*;

    logic [ID_W-1:0]      r_id;
    logic [TIME_BITS-1:0] r_delta;
    logic [ID_W-1:0]      n_id;
    logic [TIME_BITS-1:0] n_delta;

    always_comb begin
        n_id    = r_id;
        n_delta = r_delta;
        unique case (i_ctl.cmd)
            CELL_HOLD: ;
            CELL_SHL: begin
                n_id    = i_right_id;
                n_delta = i_right_delta;
            end
            CELL_SHL_ADD: begin
                n_id    = i_right_id;
                n_delta = i_right_delta + r_delta;
            end
            CELL_SHR: begin
                n_id    = i_left_id;
                n_delta = i_left_delta;
            end
            CELL_SHR_SUB: begin
                n_id    = i_left_id;
                n_delta = i_left_delta - i_operand;
            end
            CELL_LOAD: begin
                n_id    = i_ctl.new_id;
                n_delta = i_operand;
            end
            CELL_SUB: n_delta = r_delta - i_operand;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_delta <= n_delta;
    end

    assign o_id    = r_id;
    assign o_delta = r_delta;

endmodule

### hdl/delta_list_timer_queue_top.sv
// Top level of the delta list timer queue: control sequencer and cell chain.
// Depends on dlq_pkg, dlq_in_if, dlq_out_if and dlq_cell.
//
// Usage:
//  i_in carries one command per transfer: op (time update, schedule, cancel),
//  timer_id and value (time stamp or delay). o_out carries expired timer ids.
//  The queue is a row of cells in expiry order; cell 0 is the head and each
//  cell holds its delta to the cell before it. Cells shift left on removal and
//  right on insertion, each taking its neighbor's content.
//  One command at a time, i_in.ready high when idle:
//    time update : the expired id is presented at the end of it
//    cancel      : ends early when the timer is not in the list
//    schedule    : walks k list entries (0..count), after cancelling the
//                  timer first when it was already active.
//  The schedule walk, one cell compare and subtract per cycle, makes
//  schedule the longest command.
//  Reset empties the queue and clears the last time stamp and carry; no
//  clearing pass is needed. A finished result waits in the output register
//  while new commands are taken; a time update that pops waits only while
//  that register is still full and o_out.ready is low.
module delta_list_timer_queue_top #(
    parameter int NUM_TIMERS = dlq_pkg::DLQ_NUM_TIMERS,
    parameter int TIME_BITS  = dlq_pkg::DLQ_TIME_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dlq_in_if.sink            i_in,
    dlq_out_if.source         o_out
);
    import dlq_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int PW = $clog2(NUM_TIMERS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_TICK,
        S_CANCEL,
        S_SCAN,
        S_INSERT
    } t_state;

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [ID_W-1:0]      r_id, n_id;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic [TIME_BITS-1:0] r_rem, n_rem;
    logic [PW-1:0]        r_pos, n_pos;
    logic [PW-1:0]        r_count, n_count;
    logic [TIME_BITS-1:0] r_last, n_last;
    logic [TIME_BITS-1:0] r_carry, n_carry;
    logic                 r_out_valid, n_out_valid;
    logic [ID_W-1:0]      r_out_id, n_out_id;

    logic [ID_W-1:0]      w_id    [NUM_TIMERS];
    logic [TIME_BITS-1:0] w_delta [NUM_TIMERS];
    t_cell_ctl            w_ctl   [NUM_TIMERS];

    logic                 w_found;
    logic [PW-1:0]        w_match_pos;
    logic [TIME_BITS-1:0] w_scan_delta;
    logic [TIME_BITS-1:0] w_stamp;
    logic                 w_id_ok;

    // Cell chain
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        logic [ID_W-1:0]      w_lid, w_rid;
        logic [TIME_BITS-1:0] w_ld, w_rd;
        if (g == 0) begin : g_first
            assign w_lid = '0;
            assign w_ld  = '0;
        end else begin : g_mid_l
            assign w_lid = w_id[g-1];
            assign w_ld  = w_delta[g-1];
        end
        if (g == NUM_TIMERS - 1) begin : g_last
            assign w_rid = '0;
            assign w_rd  = '0;
        end else begin : g_mid_r
            assign w_rid = w_id[g+1];
            assign w_rd  = w_delta[g+1];
        end
        dlq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl[g]),
            .i_operand     (r_rem),
            .i_left_id     (w_lid),
            .i_left_delta  (w_ld),
            .i_right_id    (w_rid),
            .i_right_delta (w_rd),
            .o_id          (w_id[g]),
            .o_delta       (w_delta[g])
        );
    end

    // Position of r_id in the list; ids are unique among valid cells.
    always_comb begin
        w_found     = 1'b0;
        w_match_pos = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if ((PW'(i) < r_count) && (w_id[i] == r_id)) begin
                w_found     = 1'b1;
                w_match_pos = PW'(i);
            end
        end
    end

    assign w_id_ok      = (int'(r_id) < NUM_TIMERS);
    assign w_scan_delta = w_delta[r_pos[IW-1:0]];
    assign w_stamp      = TIME_BITS'(r_value);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_id        = r_id;
        n_value     = r_value;
        n_rem       = r_rem;
        n_pos       = r_pos;
        n_count     = r_count;
        n_last      = r_last;
        n_carry     = r_carry;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_id    = r_out_id;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            w_ctl[i].cmd    = CELL_HOLD;
            w_ctl[i].new_id = r_id;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op    = t_op'(i_in.op);
                    n_id    = i_in.timer_id;
                    n_value = i_in.value;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_op)
                    OP_TIME: begin
                        n_rem   = w_stamp - r_last + r_carry;
                        n_last  = w_stamp;
                        n_state = S_TICK;
                    end
                    OP_SCHED: begin
                        n_rem = w_stamp;
                        n_pos = '0;
                        if (!w_id_ok) begin
                            n_state = S_IDLE;
                        end else if (w_found) begin
                            n_state = S_CANCEL;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_CANCEL: begin
                        n_state = (w_id_ok && w_found) ? S_CANCEL : S_IDLE;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_TICK: begin
                if (r_count == '0) begin
                    n_carry = '0;
                    n_state = S_IDLE;
                end else if (w_delta[0] > r_rem) begin
                    w_ctl[0].cmd = CELL_SUB;
                    n_carry      = '0;
                    n_state      = S_IDLE;
                end else if (!r_out_valid || o_out.ready) begin
                    // pop the head
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        w_ctl[i].cmd = CELL_SHL;
                    end
                    n_carry     = r_rem - w_delta[0];
                    n_count     = r_count - 1'b1;
                    n_out_valid = 1'b1;
                    n_out_id    = w_id[0];
                    n_state     = S_IDLE;
                end
            end
            S_CANCEL: begin
                // successor absorbs the removed delta, tail moves left
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (PW'(i) == w_match_pos) begin
                        w_ctl[i].cmd = CELL_SHL_ADD;
                    end else if (PW'(i) > w_match_pos) begin
                        w_ctl[i].cmd = CELL_SHL;
                    end
                end
                n_count = r_count - 1'b1;
                n_pos   = '0;
                n_state = (r_op == OP_SCHED) ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                if (r_pos == r_count || r_rem <= w_scan_delta) begin
                    n_state = S_INSERT;
                end else begin
                    n_rem = r_rem - w_scan_delta;
                    n_pos = r_pos + 1'b1;
                end
            end
            S_INSERT: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (i == int'(r_pos)) begin
                        w_ctl[i].cmd = CELL_LOAD;
                    end else if (i == int'(r_pos) + 1) begin
                        w_ctl[i].cmd = CELL_SHR_SUB;
                    end else if (i > int'(r_pos)) begin
                        w_ctl[i].cmd = CELL_SHR;
                    end
                end
                n_count = r_count + 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_last      <= '0;
            r_carry     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_last      <= n_last;
            r_carry     <= n_carry;
            r_out_valid <= n_out_valid;
        end
        r_op     <= n_op;
        r_id     <= n_id;
        r_value  <= n_value;
        r_rem    <= n_rem;
        r_pos    <= n_pos;
        r_out_id <= n_out_id;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.expired_id = r_out_id;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= PW'(NUM_TIMERS))
        else $error("timer count exceeds capacity");

    a_insert_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT) |-> (r_pos <= r_count && r_count < PW'(NUM_TIMERS)))
        else $error("insert position or count out of range");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_DECODE))
        else $error("accepted command not decoded");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && n_count != r_count) |-> (r_count != '0))
        else $error("pop from empty queue");
`endif

endmodule
